### rtl/rhdc_pkg.sv
// Package for the ramped H-bridge drive controller.
// Holds the mode, command and reply codes and the state and result structs.
// No dependencies.
`timescale 1ns / 1ps

package rhdc_pkg;

   // Operating modes
   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_RUN   = 2'd1,
      MODE_FAULT = 2'd2,
      MODE_STOP  = 2'd3
   } mode_type;

   // Request function codes
   typedef enum logic [2:0] {
      FUNC_TICK      = 3'd0,
      FUNC_SET_SPEED = 3'd1,
      FUNC_STOP      = 3'd2,
      FUNC_STATUS    = 3'd3,
      FUNC_HEARTBEAT = 3'd4,
      FUNC_RESET     = 3'd5
   } func_type;

   // Reply codes
   typedef enum logic [2:0] {
      REPLY_NONE        = 3'd0,
      REPLY_ACK         = 3'd1,
      REPLY_STATUS      = 3'd2,
      REPLY_NACK_PAYLD  = 3'd3,
      REPLY_NACK_UNKNWN = 3'd4
   } reply_type;

   // Register indexes on the CSR port
   localparam logic REG_RAMP_STEP = 1'b0;
   localparam logic REG_TIMEOUT   = 1'b1;

   localparam int DUTY_LIMIT = 100;
   localparam int FULL_STEP  = 100;
   localparam logic [6:0]  RAMP_STEP_RESET = 7'd5;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd50;
   localparam logic [15:0] AGE_MAX         = 16'hFFFF;

   // Controller state
   typedef struct packed {
      mode_type          mode;
      logic signed [7:0] goal_left;
      logic signed [7:0] goal_right;
      logic signed [7:0] duty_left;
      logic signed [7:0] duty_right;
      logic              smoothing_on;
      logic [15:0]       heartbeat_age;
      logic              fault_flag;
      logic              stop_pending;
   } state_type;

   // One response item
   typedef struct packed {
      reply_type         reply;
      logic [6:0]        left_forward_duty;
      logic [6:0]        left_reverse_duty;
      logic [6:0]        right_forward_duty;
      logic [6:0]        right_reverse_duty;
      logic              drive_enable;
      logic signed [7:0] actual_left_out;
      logic signed [7:0] actual_right_out;
      mode_type          mode_out;
      logic              fault_out;
   } result_type;

endpackage

### rtl/ramped_hbridge_drive_controller.sv
// Top level of the ramped two-motor H-bridge drive controller.
// Holds the request stage, controller state, CSRs and response register.
// Depends on rhdc_pkg and rhdc_step.
`timescale 1ns / 1ps

// Usage
//   Request channel (req_*): one decoded host command or control tick per
//   request; func selects tick, set speed, stop, status, heartbeat or reset.
//   Response channel (rsp_*): exactly one response per request, in order,
//   carrying the reply code and the drive outputs after that request.
//   CSR port: APB-style, register 0 (ramp_step) at 0x0, register 1
//   (heartbeat_timeout_ticks) at 0x4; pready is tied high.
// Stages and throughput
//   A request is registered into the request stage at acceptance; when it
//   advances, its response and the state update are registered together,
//   the response in the response register. One request per cycle is
//   sustained while rsp_ready stays high; the state update is a single
//   combinational pass, so a request can follow straight behind the last.
// Reset
//   Synchronous reset empties both stages, puts the controller in idle with
//   zero targets and duties, smoothing on, and the CSRs at ramp step 5 and
//   timeout 50 ticks.
// Stall
//   While rsp_ready is low the response holds; one more request is taken
//   into the request stage, then req_ready drops until the response moves.

module ramped_hbridge_drive_controller (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic signed [15:0] req_speed_left,
   input  logic signed [15:0] req_speed_right,
   input  logic               req_smooth_ramp,
   input  logic               req_payload_short,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_reply,
   output logic [6:0]         rsp_left_forward_duty,
   output logic [6:0]         rsp_left_reverse_duty,
   output logic [6:0]         rsp_right_forward_duty,
   output logic [6:0]         rsp_right_reverse_duty,
   output logic               rsp_drive_enable,
   output logic signed [7:0]  rsp_actual_left_out,
   output logic signed [7:0]  rsp_actual_right_out,
   output logic [1:0]         rsp_mode_out,
   output logic               rsp_fault_out,
   // CSR port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // Request stage
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [2:0]          s1_func_ff;
   logic signed [15:0]  s1_speed_left_ff;
   logic signed [15:0]  s1_speed_right_ff;
   logic                s1_smooth_ff;
   logic                s1_short_ff;

   // Response stage
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rhdc_pkg::result_type rsp_ff;
   rhdc_pkg::result_type rsp_in;

   // Controller state and CSRs
   rhdc_pkg::state_type st_ff;
   rhdc_pkg::state_type st_in;
   logic [6:0]          ramp_step_ff;
   logic [15:0]         timeout_ff;

   logic                advance;
   logic                req_take;
   logic                csr_write;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign csr_write = psel && penable && pwrite && pready;

   // Handshake control
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request payload register
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff        <= req_func;
         s1_speed_left_ff  <= req_speed_left;
         s1_speed_right_ff <= req_speed_right;
         s1_smooth_ff      <= req_smooth_ramp;
         s1_short_ff       <= req_payload_short;
      end
   end

   // State update and response computation
   rhdc_step u_step (
      .st            (st_ff),
      .func          (s1_func_ff),
      .spd_left      (s1_speed_left_ff),
      .spd_right     (s1_speed_right_ff),
      .smooth_ramp   (s1_smooth_ff),
      .payload_short (s1_short_ff),
      .ramp_step     (ramp_step_ff),
      .timeout_ticks (timeout_ff),
      .st_next       (st_in),
      .result        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.mode          <= rhdc_pkg::MODE_IDLE;
         st_ff.goal_left     <= '0;
         st_ff.goal_right    <= '0;
         st_ff.duty_left     <= '0;
         st_ff.duty_right    <= '0;
         st_ff.smoothing_on  <= 1'b1;
         st_ff.heartbeat_age <= '0;
         st_ff.fault_flag    <= 1'b0;
         st_ff.stop_pending  <= 1'b0;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // CSR registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_step_ff <= rhdc_pkg::RAMP_STEP_RESET;
         timeout_ff   <= rhdc_pkg::TIMEOUT_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            rhdc_pkg::REG_RAMP_STEP: ramp_step_ff <= pwdata[6:0];
            rhdc_pkg::REG_TIMEOUT:   timeout_ff   <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // CSR read
   always_comb begin
      case (paddr[2])
         rhdc_pkg::REG_RAMP_STEP: prdata = {25'd0, ramp_step_ff};
         rhdc_pkg::REG_TIMEOUT:   prdata = {16'd0, timeout_ff};
         default:                 prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // Response ports
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_reply              = rsp_ff.reply;
   assign rsp_left_forward_duty  = rsp_ff.left_forward_duty;
   assign rsp_left_reverse_duty  = rsp_ff.left_reverse_duty;
   assign rsp_right_forward_duty = rsp_ff.right_forward_duty;
   assign rsp_right_reverse_duty = rsp_ff.right_reverse_duty;
   assign rsp_drive_enable       = rsp_ff.drive_enable;
   assign rsp_actual_left_out    = rsp_ff.actual_left_out;
   assign rsp_actual_right_out   = rsp_ff.actual_right_out;
   assign rsp_mode_out           = rsp_ff.mode_out;
   assign rsp_fault_out          = rsp_ff.fault_out;

endmodule

### rtl/rhdc_step.sv
// Single-pass update of the drive controller for one request.
// Computes the next controller state and the response from the current state.
// Depends on rhdc_pkg.
`timescale 1ns / 1ps

module rhdc_step (
   input  rhdc_pkg::state_type  st,
   input  logic [2:0]           func,
   input  logic signed [15:0]   spd_left,
   input  logic signed [15:0]   spd_right,
   input  logic                 smooth_ramp,
   input  logic                 payload_short,
   input  logic [6:0]           ramp_step,
   input  logic [15:0]          timeout_ticks,
   output rhdc_pkg::state_type  st_next,
   output rhdc_pkg::result_type result
);

   // Clamp a requested speed to the duty limit
   function automatic logic signed [7:0] clamp_speed(input logic signed [15:0] v);
      logic signed [7:0] r;
      if (v > 16'sd100) begin
         r = 8'sd100;
      end else if (v < -16'sd100) begin
         r = -8'sd100;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   // Move cur towards tgt by at most step
   function automatic logic signed [7:0] slew(input logic signed [7:0] cur,
                                              input logic signed [7:0] tgt,
                                              input logic [6:0] step);
      logic signed [8:0] diff;
      logic signed [8:0] stp;
      logic signed [8:0] r;
      diff = 9'(tgt) - 9'(cur);
      stp  = {2'b00, step};
      if (diff > stp) begin
         r = 9'(cur) + stp;
      end else if (diff < -stp) begin
         r = 9'(cur) - stp;
      end else begin
         r = 9'(tgt);
      end
      return r[7:0];
   endfunction

   rhdc_pkg::state_type s;
   rhdc_pkg::reply_type reply;
   logic [15:0]         age_inc;
   logic [6:0]          step;
   logic signed [7:0]   new_left;
   logic signed [7:0]   new_right;

   assign age_inc = (st.heartbeat_age == rhdc_pkg::AGE_MAX) ? st.heartbeat_age
                                                            : st.heartbeat_age + 16'd1;
   assign step = st.smoothing_on ? ramp_step : 7'(rhdc_pkg::FULL_STEP);
   assign new_left  = slew(st.duty_left, st.goal_left, step);
   assign new_right = slew(st.duty_right, st.goal_right, step);

   // Next state and reply
   always_comb begin
      s     = st;
      reply = rhdc_pkg::REPLY_NONE;
      if (func == rhdc_pkg::FUNC_TICK) begin
         s.stop_pending  = 1'b0;
         s.heartbeat_age = age_inc;
         if (st.stop_pending && st.mode != rhdc_pkg::MODE_STOP) begin
            s.mode       = rhdc_pkg::MODE_STOP;
            s.goal_left  = '0;
            s.goal_right = '0;
            s.duty_left  = '0;
            s.duty_right = '0;
         end else begin
            case (st.mode)
               rhdc_pkg::MODE_IDLE: begin
                  if (st.goal_left != 0 || st.goal_right != 0) begin
                     s.mode          = rhdc_pkg::MODE_RUN;
                     s.heartbeat_age = '0;
                  end
               end
               rhdc_pkg::MODE_RUN: begin
                  if (age_inc > timeout_ticks) begin
                     s.mode       = rhdc_pkg::MODE_FAULT;
                     s.fault_flag = 1'b1;
                     s.goal_left  = '0;
                     s.goal_right = '0;
                     s.duty_left  = '0;
                     s.duty_right = '0;
                  end else begin
                     s.duty_left  = new_left;
                     s.duty_right = new_right;
                     if (st.goal_left == 0 && st.goal_right == 0 &&
                         new_left == 0 && new_right == 0) begin
                        s.mode = rhdc_pkg::MODE_IDLE;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end else begin
         // every command refreshes the watchdog
         s.heartbeat_age = '0;
         case (func)
            rhdc_pkg::FUNC_SET_SPEED: begin
               if (payload_short) begin
                  reply = rhdc_pkg::REPLY_NACK_PAYLD;
               end else begin
                  s.goal_left    = clamp_speed(spd_left);
                  s.goal_right   = clamp_speed(spd_right);
                  s.smoothing_on = smooth_ramp;
                  reply          = rhdc_pkg::REPLY_ACK;
               end
            end
            rhdc_pkg::FUNC_STOP: begin
               s.goal_left    = '0;
               s.goal_right   = '0;
               s.duty_left    = '0;
               s.duty_right   = '0;
               s.stop_pending = 1'b1;
               reply          = rhdc_pkg::REPLY_ACK;
            end
            rhdc_pkg::FUNC_STATUS: begin
               reply = rhdc_pkg::REPLY_STATUS;
            end
            rhdc_pkg::FUNC_HEARTBEAT: begin
               reply = rhdc_pkg::REPLY_ACK;
            end
            rhdc_pkg::FUNC_RESET: begin
               s.fault_flag   = 1'b0;
               s.stop_pending = 1'b0;
               s.mode         = rhdc_pkg::MODE_IDLE;
               s.goal_left    = '0;
               s.goal_right   = '0;
               s.duty_left    = '0;
               s.duty_right   = '0;
               reply          = rhdc_pkg::REPLY_ACK;
            end
            default: begin
               reply = rhdc_pkg::REPLY_NACK_UNKNWN;
            end
         endcase
      end
   end

   assign st_next = s;

   // Response fields from the updated state
   always_comb begin
      result.reply              = reply;
      result.left_forward_duty  = (s.duty_left > 0)  ? s.duty_left[6:0]  : 7'd0;
      result.left_reverse_duty  = (s.duty_left < 0)  ? 7'(-s.duty_left)  : 7'd0;
      result.right_forward_duty = (s.duty_right > 0) ? s.duty_right[6:0] : 7'd0;
      result.right_reverse_duty = (s.duty_right < 0) ? 7'(-s.duty_right) : 7'd0;
      result.drive_enable       = (s.mode == rhdc_pkg::MODE_RUN);
      result.actual_left_out    = s.duty_left;
      result.actual_right_out   = s.duty_right;
      result.mode_out           = s.mode;
      result.fault_out          = s.fault_flag;
   end

endmodule

### tb/sv/tb_ramped_hbridge_drive_controller.sv
// Self-checking testbench for ramped_hbridge_drive_controller.
// Drives commands and ticks, predicts every response and checks it field by field.
// Depends on rhdc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_ramped_hbridge_drive_controller;

   localparam logic [2:0] FUNC_UNKNOWN  = 3'd6;
   localparam logic [2:0] FUNC_RESERVED = 3'd7;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRINT_CAP      = 40;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 210;

   typedef struct {
      logic [2:0]         func;
      logic signed [15:0] spd_left;
      logic signed [15:0] spd_right;
      logic               smooth_ramp;
      logic               payload_short;
   } drive_cmd_type;

   // DUT-facing signals; the inputs are known from time zero
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_func = 3'd0;
   logic signed [15:0] req_speed_left = 16'sd0;
   logic signed [15:0] req_speed_right = 16'sd0;
   logic               req_smooth_ramp = 1'b0;
   logic               req_payload_short = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b1;
   logic [2:0]         rsp_reply;
   logic [6:0]         rsp_left_forward_duty;
   logic [6:0]         rsp_left_reverse_duty;
   logic [6:0]         rsp_right_forward_duty;
   logic [6:0]         rsp_right_reverse_duty;
   logic               rsp_drive_enable;
   logic signed [7:0]  rsp_actual_left_out;
   logic signed [7:0]  rsp_actual_right_out;
   logic [1:0]         rsp_mode_out;
   logic               rsp_fault_out;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = 3'd0;
   logic [31:0]        pwdata = 32'd0;
   logic [31:0]        prdata;
   logic               pready;

   // Controller model state and registers
   rhdc_pkg::mode_type mdl_mode;
   logic signed [7:0]  mdl_tgt_left, mdl_tgt_right;
   logic signed [7:0]  mdl_act_left, mdl_act_right;
   logic               mdl_smooth;
   logic [15:0]        mdl_age;
   logic               mdl_fault;
   logic               mdl_stop_pending;
   logic [6:0]         mdl_ramp_step;
   logic [15:0]        mdl_timeout;

   // Bookkeeping
   drive_cmd_type        pending_cmd_q[$];
   rhdc_pkg::result_type expected_drive_q[$];
   int                 mismatches = 0;
   int                 issued = 0;
   int                 accepted = 0;
   int                 responses = 0;
   int                 idle_cycles = 0;
   int                 phase_queued = 0;
   int                 settings_done = 0;
   int                 faults_seen = 0;
   int                 stops_seen = 0;
   int                 req_gap = 0;
   int                 rsp_stall = 0;
   logic               req_hs = 1'b0;
   logic               no_idle = 1'b0;

   ramped_hbridge_drive_controller u_top (.*);

   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // Controller model
   // ---------------------------------------------------------------
   function automatic logic signed [7:0] clamp_duty(logic signed [15:0] raw);
      int v;
      v = raw;
      if (v > rhdc_pkg::DUTY_LIMIT) v = rhdc_pkg::DUTY_LIMIT;
      if (v < -rhdc_pkg::DUTY_LIMIT) v = -rhdc_pkg::DUTY_LIMIT;
      return 8'(v);
   endfunction

   function automatic logic signed [7:0] slew_duty(logic signed [7:0] cur,
                                                   logic signed [7:0] tgt, int step);
      int diff;
      diff = int'(tgt) - int'(cur);
      if (diff > step) return 8'(int'(cur) + step);
      if (diff < -step) return 8'(int'(cur) - step);
      return tgt;
   endfunction

   function automatic void zero_motion();
      mdl_tgt_left = 8'sd0;
      mdl_tgt_right = 8'sd0;
      mdl_act_left = 8'sd0;
      mdl_act_right = 8'sd0;
   endfunction

   function automatic void reset_drive_model();
      mdl_mode = rhdc_pkg::MODE_IDLE;
      zero_motion();
      mdl_smooth = 1'b1;
      mdl_age = 16'd0;
      mdl_fault = 1'b0;
      mdl_stop_pending = 1'b0;
      mdl_ramp_step = rhdc_pkg::RAMP_STEP_RESET;
      mdl_timeout = rhdc_pkg::TIMEOUT_RESET;
   endfunction

   // One tick: stop event first, then the mode's own work
   function automatic void drive_tick();
      logic stop_now;
      int   step;
      stop_now = mdl_stop_pending;
      mdl_stop_pending = 1'b0;
      if (mdl_age != rhdc_pkg::AGE_MAX) mdl_age = mdl_age + 16'd1;
      if (stop_now && mdl_mode != rhdc_pkg::MODE_STOP) begin
         mdl_mode = rhdc_pkg::MODE_STOP;
         zero_motion();
         stops_seen++;
      end else if (mdl_mode == rhdc_pkg::MODE_IDLE) begin
         if (mdl_tgt_left != 0 || mdl_tgt_right != 0) begin
            mdl_mode = rhdc_pkg::MODE_RUN;
            mdl_age = 16'd0;
         end
      end else if (mdl_mode == rhdc_pkg::MODE_RUN) begin
         if (mdl_age > mdl_timeout) begin
            mdl_mode = rhdc_pkg::MODE_FAULT;
            mdl_fault = 1'b1;
            zero_motion();
            faults_seen++;
         end else begin
            step = mdl_smooth ? int'(mdl_ramp_step) : rhdc_pkg::FULL_STEP;
            mdl_act_left = slew_duty(mdl_act_left, mdl_tgt_left, step);
            mdl_act_right = slew_duty(mdl_act_right, mdl_tgt_right, step);
            if (mdl_tgt_left == 0 && mdl_tgt_right == 0 &&
                mdl_act_left == 0 && mdl_act_right == 0)
               mdl_mode = rhdc_pkg::MODE_IDLE;
         end
      end
   endfunction

   // Applies one request and returns the response it produces
   function automatic rhdc_pkg::result_type drive_model_step(drive_cmd_type c);
      rhdc_pkg::result_type r;
      int mag_l, mag_r;
      r.reply = rhdc_pkg::REPLY_NONE;
      if (c.func == rhdc_pkg::FUNC_TICK) begin
         drive_tick();
      end else begin
         mdl_age = 16'd0;
         case (c.func)
            rhdc_pkg::FUNC_SET_SPEED: begin
               if (c.payload_short) begin
                  r.reply = rhdc_pkg::REPLY_NACK_PAYLD;
               end else begin
                  mdl_tgt_left = clamp_duty(c.spd_left);
                  mdl_tgt_right = clamp_duty(c.spd_right);
                  mdl_smooth = c.smooth_ramp;
                  r.reply = rhdc_pkg::REPLY_ACK;
               end
            end
            rhdc_pkg::FUNC_STOP: begin
               zero_motion();
               mdl_stop_pending = 1'b1;
               r.reply = rhdc_pkg::REPLY_ACK;
            end
            rhdc_pkg::FUNC_STATUS:    r.reply = rhdc_pkg::REPLY_STATUS;
            rhdc_pkg::FUNC_HEARTBEAT: r.reply = rhdc_pkg::REPLY_ACK;
            rhdc_pkg::FUNC_RESET: begin
               mdl_fault = 1'b0;
               mdl_stop_pending = 1'b0;
               mdl_mode = rhdc_pkg::MODE_IDLE;
               zero_motion();
               r.reply = rhdc_pkg::REPLY_ACK;
            end
            default:        r.reply = rhdc_pkg::REPLY_NACK_UNKNWN;
         endcase
      end
      mag_l = (mdl_act_left < 0) ? -int'(mdl_act_left) : int'(mdl_act_left);
      mag_r = (mdl_act_right < 0) ? -int'(mdl_act_right) : int'(mdl_act_right);
      r.left_forward_duty = (mdl_act_left > 0) ? 7'(mag_l) : 7'd0;
      r.left_reverse_duty = (mdl_act_left < 0) ? 7'(mag_l) : 7'd0;
      r.right_forward_duty = (mdl_act_right > 0) ? 7'(mag_r) : 7'd0;
      r.right_reverse_duty = (mdl_act_right < 0) ? 7'(mag_r) : 7'd0;
      r.drive_enable = (mdl_mode == rhdc_pkg::MODE_RUN);
      r.actual_left_out = mdl_act_left;
      r.actual_right_out = mdl_act_right;
      r.mode_out = mdl_mode;
      r.fault_out = mdl_fault;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Reporting and idle lengths
   // ---------------------------------------------------------------
   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatches++;
   endtask

   // Mostly zero, often short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------
   // Request driver: feeds pending_cmd_q onto the request channel
   // ---------------------------------------------------------------
   always @(negedge clock) begin : drive_requests
      drive_cmd_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_hs) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_cmd_q.size() != 0) begin
            c = pending_cmd_q.pop_front();
            req_func <= c.func;
            req_speed_left <= c.spd_left;
            req_speed_right <= c.spd_right;
            req_smooth_ramp <= c.smooth_ramp;
            req_payload_short <= c.payload_short;
            req_valid <= 1'b1;
            issued++;
            req_gap = no_idle ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!no_idle && $urandom_range(0, 99) < 20) rsp_stall = pick_gap();
      end
   end

   // ---------------------------------------------------------------
   // Monitor: predicts on each accepted request, checks each response
   // ---------------------------------------------------------------
   always @(posedge clock) begin : sample_outputs
      rhdc_pkg::result_type want;
      drive_cmd_type c;
      logic       busy;
      busy = 1'b0;
      req_hs = !reset && req_valid && req_ready;
      if (!reset) begin
         // older traffic first: the response side
         if (rsp_valid && rsp_ready) begin
            busy = 1'b1;
            if (expected_drive_q.size() == 0) begin
               report_mismatch($sformatf("response %0d with nothing expected", responses));
            end else begin
               want = expected_drive_q.pop_front();
               if (rsp_reply !== want.reply)
                  report_mismatch($sformatf("rsp %0d reply got %0d exp %0d",
                                            responses, rsp_reply, want.reply));
               if (rsp_left_forward_duty !== want.left_forward_duty)
                  report_mismatch($sformatf("rsp %0d left_fwd got %0d exp %0d", responses,
                                            rsp_left_forward_duty, want.left_forward_duty));
               if (rsp_left_reverse_duty !== want.left_reverse_duty)
                  report_mismatch($sformatf("rsp %0d left_rev got %0d exp %0d", responses,
                                            rsp_left_reverse_duty, want.left_reverse_duty));
               if (rsp_right_forward_duty !== want.right_forward_duty)
                  report_mismatch($sformatf("rsp %0d right_fwd got %0d exp %0d", responses,
                                            rsp_right_forward_duty, want.right_forward_duty));
               if (rsp_right_reverse_duty !== want.right_reverse_duty)
                  report_mismatch($sformatf("rsp %0d right_rev got %0d exp %0d", responses,
                                            rsp_right_reverse_duty, want.right_reverse_duty));
               if (rsp_drive_enable !== want.drive_enable)
                  report_mismatch($sformatf("rsp %0d enable got %0d exp %0d", responses,
                                            rsp_drive_enable, want.drive_enable));
               if (rsp_actual_left_out !== want.actual_left_out)
                  report_mismatch($sformatf("rsp %0d left duty got %0d exp %0d", responses,
                                            rsp_actual_left_out, want.actual_left_out));
               if (rsp_actual_right_out !== want.actual_right_out)
                  report_mismatch($sformatf("rsp %0d right duty got %0d exp %0d", responses,
                                            rsp_actual_right_out, want.actual_right_out));
               if (rsp_mode_out !== want.mode_out)
                  report_mismatch($sformatf("rsp %0d mode got %0d exp %0d", responses,
                                            rsp_mode_out, want.mode_out));
               if (rsp_fault_out !== want.fault_out)
                  report_mismatch($sformatf("rsp %0d fault got %0d exp %0d", responses,
                                            rsp_fault_out, want.fault_out));
            end
            responses++;
         end
         if (req_hs) begin
            busy = 1'b1;
            c.func = req_func;
            c.spd_left = req_speed_left;
            c.spd_right = req_speed_right;
            c.smooth_ramp = req_smooth_ramp;
            c.payload_short = req_payload_short;
            expected_drive_q.push_back(drive_model_step(c));
            accepted++;
         end
         if (psel && penable && pready) busy = 1'b1;
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
   end

   // Watchdog: no handshake of any kind for too long
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
               WATCHDOG_LIMIT, expected_drive_q.size());
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic queue_cmd(input logic [2:0] func, input logic signed [15:0] left,
                            input logic signed [15:0] right, input logic smooth,
                            input logic short_pl);
      drive_cmd_type c;
      c.func = func;
      c.spd_left = left;
      c.spd_right = right;
      c.smooth_ramp = smooth;
      c.payload_short = short_pl;
      pending_cmd_q.push_back(c);
      phase_queued++;
   endtask

   // Tick with junk in the fields it ignores
   task automatic queue_tick();
      queue_cmd(rhdc_pkg::FUNC_TICK, 16'($urandom), 16'($urandom), 1'($urandom),
                1'($urandom));
   endtask

   function automatic logic signed [15:0] rand_speed();
      case ($urandom_range(0, 9))
         0:       return 16'sd0;
         1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         2:       return $urandom_range(0, 1) ? 16'(101 - 2 * $urandom_range(0, 1))
                                              : 16'(-101 + 2 * $urandom_range(0, 1));
         3:       return 16'($urandom);
         default: return 16'(int'($urandom_range(0, 200)) - 100);
      endcase
   endfunction

   function automatic logic signed [15:0] rand_nonzero_speed();
      int v;
      v = $urandom_range(1, 100);
      return $urandom_range(0, 1) ? 16'(v) : 16'(-v);
   endfunction

   // Well-formed drive sequences with random content, plus some noise
   task automatic queue_random_phase(input int quota);
      int s, n;
      phase_queued = 0;
      while (phase_queued < quota) begin
         s = $urandom_range(0, 99);
         if (s < 55) begin
            // set speed, then ramp with the odd keep-alive in between
            queue_cmd(rhdc_pkg::FUNC_SET_SPEED, rand_speed(), rand_speed(), 1'($urandom),
                      $urandom_range(0, 19) == 0);
            repeat ($urandom_range(1, 25)) begin
               if ($urandom_range(0, 7) == 0) begin
                  case ($urandom_range(0, 2))
                     0: queue_cmd(rhdc_pkg::FUNC_HEARTBEAT, 16'($urandom), 16'($urandom),
                                  1'b0, 1'b0);
                     1: queue_cmd(rhdc_pkg::FUNC_STATUS, 16'($urandom), 16'($urandom),
                                  1'b1, 1'b1);
                     default: queue_cmd(rhdc_pkg::FUNC_SET_SPEED, rand_speed(), rand_speed(),
                                        1'($urandom), 1'b0);
                  endcase
               end
               queue_tick();
            end
         end else if (s < 65) begin
            // run, then go silent long enough to trip the watchdog where it can
            queue_cmd(rhdc_pkg::FUNC_SET_SPEED, rand_nonzero_speed(), rand_speed(),
                      1'($urandom), 1'b0);
            n = (mdl_timeout < 200) ? int'(mdl_timeout) + 3 : $urandom_range(10, 40);
            repeat (n) queue_tick();
            if ($urandom_range(0, 1))
               queue_cmd(rhdc_pkg::FUNC_RESET, 16'($urandom), 16'($urandom), 1'b0, 1'b0);
         end else if (s < 75) begin
            // stop while moving, then poke the latched mode
            queue_cmd(rhdc_pkg::FUNC_SET_SPEED, rand_nonzero_speed(), rand_nonzero_speed(),
                      1'($urandom), 1'b0);
            repeat ($urandom_range(1, 4)) queue_tick();
            queue_cmd(rhdc_pkg::FUNC_STOP, 16'($urandom), 16'($urandom), 1'($urandom),
                      1'($urandom));
            repeat ($urandom_range(0, 3)) queue_tick();
            if ($urandom_range(0, 1)) begin
               queue_cmd(rhdc_pkg::FUNC_SET_SPEED, rand_speed(), rand_speed(),
                         1'($urandom), 1'b0);
               queue_tick();
            end
            if ($urandom_range(0, 9) < 7)
               queue_cmd(rhdc_pkg::FUNC_RESET, 16'($urandom), 16'($urandom), 1'b0, 1'b0);
         end else if (s < 85) begin
            queue_cmd(rhdc_pkg::FUNC_RESET, 16'($urandom), 16'($urandom), 1'($urandom),
                      1'($urandom));
            queue_tick();
         end else begin
            // fully random requests
            repeat ($urandom_range(1, 3))
               queue_cmd(3'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom), 1'($urandom));
         end
      end
   endtask

   // Register write followed by a read-back over the CSR port
   task automatic csr_write_check(input logic reg_sel, input logic [31:0] value,
                                  input logic [31:0] mask);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {reg_sel, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_sel == rhdc_pkg::REG_RAMP_STEP) mdl_ramp_step = value[6:0];
      else mdl_timeout = value[15:0];
      @(negedge clock);
      pwrite = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if ((prdata & mask) !== (value & mask))
         report_mismatch($sformatf("csr 0x%0h read 0x%0h exp 0x%0h",
                                   {reg_sel, 2'b00}, prdata & mask, value & mask));
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic set_registers(input logic [6:0] ramp, input logic [15:0] timeout);
      csr_write_check(rhdc_pkg::REG_RAMP_STEP, 32'(ramp), 32'h7F);
      csr_write_check(rhdc_pkg::REG_TIMEOUT, 32'(timeout), 32'hFFFF);
      settings_done++;
   endtask

   // Everything issued has come back, then a settling margin
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_cmd_q.size() != 0 || issued != accepted || expected_drive_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin : main_sequence
      logic [6:0]  ramp_tab[RANDOM_PHASES];
      logic [15:0] tmo_tab[RANDOM_PHASES];
      reset_drive_model();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reply codes, clamping, ramp, full jump, stop latch, reset
      queue_cmd(rhdc_pkg::FUNC_STATUS, 16'sd0, 16'sd0, 1'b0, 1'b0);
      queue_tick();
      queue_cmd(rhdc_pkg::FUNC_SET_SPEED, 16'sd1000, -16'sd1000, 1'b1, 1'b1);
      queue_cmd(FUNC_UNKNOWN, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1);
      queue_cmd(FUNC_RESERVED, 16'shFFFF, 16'sh0000, 1'b0, 1'b1);
      queue_cmd(rhdc_pkg::FUNC_SET_SPEED, 16'sh7FFF, 16'sh8000, 1'b1, 1'b0);
      repeat (4) queue_tick();
      queue_cmd(rhdc_pkg::FUNC_SET_SPEED, -16'sd1, 16'sd1, 1'b0, 1'b0);
      queue_tick();
      queue_cmd(rhdc_pkg::FUNC_HEARTBEAT, 16'sd0, 16'sd0, 1'b0, 1'b0);
      queue_cmd(rhdc_pkg::FUNC_STOP, 16'sd0, 16'sd0, 1'b0, 1'b0);
      queue_cmd(rhdc_pkg::FUNC_SET_SPEED, 16'sd100, 16'sd100, 1'b1, 1'b0);
      queue_tick();
      queue_tick();
      // stop while already latched clears the targets but leaves the mode as it is
      queue_cmd(rhdc_pkg::FUNC_STOP, 16'sd0, 16'sd0, 1'b0, 1'b0);
      queue_tick();
      queue_cmd(rhdc_pkg::FUNC_RESET, 16'sd0, 16'sd0, 1'b0, 1'b0);
      queue_cmd(rhdc_pkg::FUNC_SET_SPEED, -16'sd101, 16'sd101, 1'b1, 1'b0);
      queue_tick();
      queue_tick();
      wait_drained();

      // Directed: heartbeat timeout fault and recovery by reset only
      set_registers(7'd100, 16'd1);
      queue_cmd(rhdc_pkg::FUNC_SET_SPEED, 16'sd50, -16'sd50, 1'b1, 1'b0);
      repeat (4) queue_tick();
      queue_cmd(rhdc_pkg::FUNC_SET_SPEED, 16'sd10, 16'sd10, 1'b1, 1'b0);
      queue_tick();
      queue_cmd(rhdc_pkg::FUNC_RESET, 16'sd0, 16'sd0, 1'b0, 1'b0);
      wait_drained();

      // Random phases over register extremes and random settings
      ramp_tab[0] = 7'd1;   tmo_tab[0] = 16'd3;
      ramp_tab[1] = 7'd100; tmo_tab[1] = 16'd65534;
      ramp_tab[2] = 7'd0;   tmo_tab[2] = 16'hFFFF;
      ramp_tab[3] = 7'h7F;  tmo_tab[3] = 16'd0;
      ramp_tab[4] = 7'($urandom_range(1, 100)); tmo_tab[4] = 16'($urandom_range(1, 120));
      ramp_tab[5] = rhdc_pkg::RAMP_STEP_RESET;
      tmo_tab[5] = 16'($urandom_range(1, 65534));
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_registers(ramp_tab[p], tmo_tab[p]);
         no_idle = (p == 3);
         queue_random_phase(PHASE_ITEMS);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      $display("Ran %0d requests through %0d register settings, %0d responses checked",
               accepted, settings_done, responses);
      $display("Heartbeat faults %0d, stop latches %0d, mismatches %0d",
               faults_seen, stops_seen, mismatches);
      if (mismatches == 0 && expected_drive_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### ramped_hbridge_drive_controller.f
rtl/rhdc_pkg.sv
rtl/rhdc_step.sv
rtl/ramped_hbridge_drive_controller.sv
tb/sv/tb_ramped_hbridge_drive_controller.sv
